@@ rtl/fprlp_pkg.sv @@
// ----------------------------------------------------------------------------
// fprlp_pkg: flash page ring log pointers, shared definitions
// Ring geometry, operation codes and the request and response words.
// ----------------------------------------------------------------------------
package fprlp_pkg;

  localparam int RING_PAGES     = 64;
  localparam int SLOTS_PER_PAGE = 512;
  localparam int TOTAL_SLOTS    = RING_PAGES * SLOTS_PER_PAGE;

  localparam int PAGE_W  = $clog2(RING_PAGES);
  localparam int OFS_W   = $clog2(SLOTS_PER_PAGE);
  localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
  localparam int CNT_W   = SLOT_W + 1;

  localparam int OP_W       = 2;
  localparam int ERASE_W    = 6;
  localparam int SLOT_OUT_W = 15;
  localparam int DATA_W     = 32;

  localparam logic [OP_W-1:0] OP_STORE = 2'd0;
  localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(RING_PAGES - 1);
  localparam logic [OFS_W-1:0]  LAST_OFS  = OFS_W'(SLOTS_PER_PAGE - 1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] record_low;
    logic [DATA_W-1:0] record_high;
  } req_t;

  typedef struct packed {
    logic                  erase_request;
    logic [ERASE_W-1:0]    erase_page;
    logic                  program_request;
    logic                  slot_valid;
    logic [SLOT_OUT_W-1:0] slot;
    logic [DATA_W-1:0]     word_low;
    logic [DATA_W-1:0]     word_high;
    logic [SLOT_OUT_W-1:0] unread_count;
  } rsp_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [PAGE_W-1:0] page,
                                                input logic [OFS_W-1:0]  ofs);
    logic [SLOT_W-1:0] base;
    base = SLOT_W'(SLOT_W'(page) * SLOT_W'(SLOTS_PER_PAGE));
    return SLOT_W'(base + SLOT_W'(ofs));
  endfunction

endpackage

@@ rtl/fprlp_ptr.sv @@
// ----------------------------------------------------------------------------
// fprlp_ptr: pointer and lap flag state
// Holds the write and read pointers and a lap flag, forms the response for
// the current request word and updates the state when step is high. Stores
// fill pages in order from page 0, so a page holds data once the write
// pointer has moved into it, or once the write pointer has gone round the
// whole ring.
// ----------------------------------------------------------------------------
module fprlp_ptr
  import fprlp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  output rsp_t rsp
);

  logic [PAGE_W-1:0] write_page, write_page_next;
  logic [OFS_W-1:0]  write_ofs, write_ofs_next;
  logic [PAGE_W-1:0] read_page, read_page_next;
  logic [OFS_W-1:0]  read_ofs, read_ofs_next;
  logic              lapped, lapped_next;

  logic [PAGE_W-1:0] after_write_page;
  logic [PAGE_W-1:0] after_read_page;
  logic              next_page_written;
  logic [SLOT_W-1:0] wr_lin, rd_lin;
  logic [CNT_W-1:0]  diff;

  assign after_write_page = (write_page == LAST_PAGE) ? '0 : PAGE_W'(write_page + 1'b1);
  assign after_read_page  = (read_page == LAST_PAGE) ? '0 : PAGE_W'(read_page + 1'b1);
  assign next_page_written = lapped || (write_page == LAST_PAGE);

  always_comb begin
    write_page_next = write_page;
    write_ofs_next  = write_ofs;
    read_page_next  = read_page;
    read_ofs_next   = read_ofs;
    lapped_next     = lapped;
    rsp             = '0;
    case (req.op)
      OP_STORE: begin
        if (write_ofs == '0) begin
          if ((read_page == write_page) && next_page_written) begin
            read_page_next = after_write_page;
            read_ofs_next  = '0;
          end
          rsp.erase_request = 1'b1;
          rsp.erase_page    = ERASE_W'(write_page);
        end
        rsp.program_request = 1'b1;
        rsp.slot            = SLOT_OUT_W'(to_slot(write_page, write_ofs));
        rsp.word_low        = req.record_low;
        rsp.word_high       = req.record_high;
        if (write_ofs == LAST_OFS) begin
          write_ofs_next  = '0;
          write_page_next = after_write_page;
          if (write_page == LAST_PAGE) begin
            lapped_next = 1'b1;
          end
        end else begin
          write_ofs_next = OFS_W'(write_ofs + 1'b1);
        end
      end
      OP_FETCH: begin
        if ((read_page != write_page) || (read_ofs != write_ofs)) begin
          rsp.slot_valid = 1'b1;
          rsp.slot       = SLOT_OUT_W'(to_slot(read_page, read_ofs));
          if (read_ofs == LAST_OFS) begin
            read_ofs_next  = '0;
            read_page_next = after_read_page;
          end else begin
            read_ofs_next = OFS_W'(read_ofs + 1'b1);
          end
        end
      end
      OP_CLEAR: begin
        write_page_next = '0;
        write_ofs_next  = '0;
        read_page_next  = '0;
        read_ofs_next   = '0;
        lapped_next     = 1'b0;
      end
      default: begin
      end
    endcase
    wr_lin = to_slot(write_page_next, write_ofs_next);
    rd_lin = to_slot(read_page_next, read_ofs_next);
    if (wr_lin >= rd_lin) begin
      diff = CNT_W'(CNT_W'(wr_lin) - CNT_W'(rd_lin));
    end else begin
      diff = CNT_W'(CNT_W'(wr_lin) + CNT_W'(TOTAL_SLOTS) - CNT_W'(rd_lin));
    end
    rsp.unread_count = SLOT_OUT_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_page <= '0;
      write_ofs  <= '0;
      read_page  <= '0;
      read_ofs   <= '0;
      lapped     <= 1'b0;
    end else if (step) begin
      write_page <= write_page_next;
      write_ofs  <= write_ofs_next;
      read_page  <= read_page_next;
      read_ofs   <= read_ofs_next;
      lapped     <= lapped_next;
    end
  end

endmodule

@@ rtl/flash_page_ring_log_pointers.sv @@
// ----------------------------------------------------------------------------
// flash_page_ring_log_pointers: pointer manager for a flash record ring
// Issues erase and program commands for stores, hands out read slots for
// fetches and reports the number of unread records after every word.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_ready  req_t: op, record_low, record_high
//   rsp      out  rsp_valid/rsp_ready  rsp_t: commands, slot, count
//
// A request word passes the pointer logic and is held in the response
// register once that register is free. One word a cycle while rsp_ready
// stays high. A stalled response holds the pass; an empty request register
// still takes one more word. Reset clears both pointers and the lap flag.
// ----------------------------------------------------------------------------
module flash_page_ring_log_pointers
  import fprlp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic req_full;
  req_t req_q;
  logic advance;
  rsp_t rsp_d;

  assign advance   = req_full && (!rsp_valid || rsp_ready);
  assign req_ready = !req_full || advance;

  fprlp_ptr u_ptr (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_q),
    .rsp  (rsp_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (advance) begin
      rsp <= rsp_d;
    end
  end

endmodule
